FILE: rtl/crpg_pkg.sv
// Package for the concentric-ring point generator: widths, register codes,
// CORDIC angle table and shared types. No dependencies.
package crpg_pkg;

  localparam int unsigned MaxRingsDef   = 255;
  localparam int unsigned MaxSpokesDef  = 255;
  localparam int unsigned PosWidthDef   = 32;
  localparam int unsigned CordicStepsDef = 24;

  localparam int unsigned RadW   = 31;
  localparam int unsigned CntW   = 8;
  localparam int unsigned PntW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 31;
  localparam int unsigned GuardBits = 8;
  localparam logic [29:0] GainQ30 = 30'd652032874;

  localparam logic [CfgIdxW-1:0] RegRadiusMax = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRingCount = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSpokes    = 2'd2;

  // Job handed from the sequencer to the point engine
  typedef struct packed {
    logic            centre;
    logic            last;
    logic [CntW-1:0] ring;
    logic [PntW-1:0] point;
    logic [PntW-1:0] count;   // spokes*k
    logic [CntW-1:0] nr;
  } job_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B; 5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53; 5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/crpg_if.sv
// Valid/ready channel interfaces for the point generator.
// Depends on crpg_pkg.
interface crpg_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface crpg_pt_if #(parameter int unsigned PosWidth = crpg_pkg::PosWidthDef);
  logic                       valid;
  logic                       ready;
  logic signed [PosWidth-1:0] pos_x;
  logic signed [PosWidth-1:0] pos_y;
  logic [crpg_pkg::CntW-1:0]  ring_index;
  logic [crpg_pkg::PntW-1:0]  point_index;
  logic                       last;
  modport source (output valid, output pos_x, output pos_y, output ring_index,
                  output point_index, output last, input ready);
  modport sink (input valid, input pos_x, input pos_y, input ring_index,
                input point_index, input last, output ready);
endinterface

interface crpg_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [crpg_pkg::CfgIdxW-1:0] index;
  logic [crpg_pkg::CfgDatW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/crpg_seq.sv
// Front end: accepts requests, walks ring/point counters, issues jobs.
// Depends on crpg_pkg.
module crpg_seq #(
  parameter int unsigned MaxRings  = crpg_pkg::MaxRingsDef,
  parameter int unsigned MaxSpokes = crpg_pkg::MaxSpokesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  logic                      restart_i,
  output logic                      req_ready_o,
  input  logic [crpg_pkg::CntW-1:0] ring_count_i,
  input  logic [crpg_pkg::CntW-1:0] spokes_i,
  output logic                      job_valid_o,
  output crpg_pkg::job_t            job_o,
  input  logic                      job_ready_i
);
  localparam int unsigned CW = crpg_pkg::CntW;
  localparam int unsigned PW = crpg_pkg::PntW;
  localparam logic [CW-1:0] MaxR =
    (MaxRings > 255) ? CW'(255) : CW'(MaxRings);
  localparam logic [CW-1:0] MaxS =
    (MaxSpokes > 255) ? CW'(255) : CW'(MaxSpokes);

  logic [CW-1:0] ring_q, ring_d;
  logic [PW-1:0] pnt_q, pnt_d;
  logic          full_q, full_d;
  crpg_pkg::job_t job_q, job_d;

  logic [CW-1:0] nr, ns, k, k0;
  logic [PW-1:0] j, j0, n;
  logic          take, zero;

  assign nr = (ring_count_i < MaxR) ? ring_count_i : MaxR;
  assign ns = (spokes_i < MaxS) ? spokes_i : MaxS;
  assign zero = (nr == '0) || (ns == '0);
  assign k0 = restart_i ? '0 : ring_q;
  assign j0 = restart_i ? '0 : pnt_q;
  // 8x8 product, one small multiplier
  assign n = PW'(ns * k0);

  assign req_ready_o = !full_q || job_ready_i;
  assign take = req_valid_i && req_ready_o;

  always_comb begin
    ring_d = ring_q;
    pnt_d  = pnt_q;
    full_d = full_q && !job_ready_i;
    job_d  = job_q;
    k = k0;
    j = j0;
    if (take) begin
      if (zero) begin
        ring_d = '0;
        pnt_d  = '0;
      end else begin
        if (k0 > nr || (k0 != '0 && j0 >= n)) begin
          k = '0;
        end
        if (k == '0) begin
          j = '0;
        end
        full_d       = 1'b1;
        job_d.centre = (k == '0);
        job_d.ring   = k;
        job_d.point  = j;
        job_d.count  = n;
        job_d.nr     = nr;
        job_d.last   = (k != '0) && (k == nr) && (j == n - 1'b1);
        if (k == '0) begin
          ring_d = CW'(1);
          pnt_d  = '0;
        end else if (PW'(j + 1'b1) >= n) begin
          ring_d = (k == nr) ? '0 : CW'(k + 1'b1);
          pnt_d  = '0;
        end else begin
          pnt_d = PW'(j + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= '0;
      pnt_q  <= '0;
      full_q <= 1'b0;
    end else begin
      ring_q <= ring_d;
      pnt_q  <= pnt_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_valid_o = full_q;
  assign job_o = job_q;
endmodule

FILE: rtl/crpg_fifo.sv
// Two-entry job queue between the sequencer and the point engine.
// Depends on crpg_pkg.
module crpg_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  crpg_pkg::job_t in_job_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output crpg_pkg::job_t out_job_o,
  input  logic           out_ready_i
);
  crpg_pkg::job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_job_o   = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_job_i;
  end
endmodule

FILE: rtl/crpg_engine.sv
// Back end: radius and turn division, shared CORDIC, result register.
// Depends on crpg_pkg.
module crpg_engine #(
  parameter int unsigned PosWidth    = crpg_pkg::PosWidthDef,
  parameter int unsigned CordicSteps = crpg_pkg::CordicStepsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  crpg_pkg::job_t                job_i,
  output logic                          job_ready_o,
  input  logic [crpg_pkg::RadW-1:0]     radius_max_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [PosWidth-1:0]    pos_x_o,
  output logic signed [PosWidth-1:0]    pos_y_o,
  output logic [crpg_pkg::CntW-1:0]     ring_index_o,
  output logic [crpg_pkg::PntW-1:0]     point_index_o,
  output logic                          last_o
);
  localparam int unsigned CW = crpg_pkg::CntW;
  localparam int unsigned PW = crpg_pkg::PntW;
  localparam int unsigned RW = crpg_pkg::RadW;
  localparam int unsigned NW = RW + CW;        // radius_max*k
  localparam int unsigned VW = 48;             // CORDIC datapath
  localparam int unsigned SW = $clog2(CordicSteps + 1);
  localparam int unsigned DW = 32;             // divider quotient bits

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StDivR = 3'd2;
  localparam logic [2:0] StDivT = 3'd3;
  localparam logic [2:0] StGain = 3'd4;
  localparam logic [2:0] StRot  = 3'd5;
  localparam logic [2:0] StFin  = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  logic [2:0] st_q, st_d;
  crpg_pkg::job_t job_q;
  logic [5:0] cnt_q, cnt_d;
  logic [NW-1:0] num_q, num_d;        // dividend shifting out
  logic [NW:0]   rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [RW-1:0] rad_q, rad_d;
  logic [DW-1:0] turn_q, turn_d;
  logic signed [VW-1:0] x_q, x_d, y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic [SW-1:0] step_q, step_d;
  logic [1:0] quad_q, quad_d;
  logic signed [PosWidth-1:0] px_q, px_d, py_q, py_d;
  logic ov_q, ov_d;

  logic [NW:0] rem_sh;
  logic [NW:0] dsor;
  logic [31:0] tq;
  logic signed [VW-1:0] xs, ys, rx, ry;
  logic [RW+29:0] gprod;

  function automatic logic signed [PosWidth-1:0] fin(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] r;
    logic signed [VW-1:0] hi, lo;
    hi = VW'((64'sd1 <<< (PosWidth - 1)) - 1);
    lo = -hi - 1;
    r = (v + VW'(1 << (crpg_pkg::GuardBits - 1))) >>> crpg_pkg::GuardBits;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return PosWidth'(r);
  endfunction

  assign dsor = (st_q == StDivR) ? (NW+1)'(job_q.nr) : (NW+1)'(job_q.count);
  assign rem_sh = {rem_q[NW-1:0], num_q[NW-1]};
  assign tq = turn_q;
  assign xs = x_q >>> step_q;
  assign ys = y_q >>> step_q;
  assign gprod = rad_q * crpg_pkg::GainQ30;

  always_comb begin
    case (quad_q)
      2'd0: begin rx = x_q; ry = y_q; end
      2'd1: begin rx = -y_q; ry = x_q; end
      2'd2: begin rx = -x_q; ry = -y_q; end
      default: begin rx = y_q; ry = -x_q; end
    endcase
  end

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; num_d = num_q; rem_d = rem_q; quo_d = quo_q;
    rad_d = rad_q; turn_d = turn_q; x_d = x_q; y_d = y_q; z_d = z_q;
    step_d = step_q; quad_d = quad_q; px_d = px_q; py_d = py_q; ov_d = ov_q;
    job_ready_o = 1'b0;
    case (st_q)
      StIdle: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          st_d = job_i.centre ? StFin : StMul;
        end
      end
      StMul: begin
        num_d = radius_max_i * job_q.ring;
        rem_d = '0; quo_d = '0; cnt_d = 6'(NW);
        st_d = StDivR;
      end
      // restoring division, one quotient bit a cycle
      StDivR, StDivT: begin
        num_d = {num_q[NW-2:0], 1'b0};
        if (rem_sh >= dsor) begin
          rem_d = rem_sh - dsor;
          quo_d = {quo_q[NW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[NW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          if (st_q == StDivR) begin
            rad_d = RW'(quo_d);
            // point sits below count, so it starts as the remainder
            num_d = '0;
            rem_d = (NW+1)'(job_q.point);
            quo_d = '0;
            cnt_d = 6'd32;
            st_d = StDivT;
          end else begin
            turn_d = quo_d[DW-1:0];
            st_d = StGain;
          end
        end
      end
      StGain: begin
        quad_d = 2'(tq + 32'h20000000 >> 30);
        z_d = 34'(signed'(tq - {quad_d, 30'd0}));
        x_d = VW'(gprod >> 22);
        y_d = '0;
        step_d = '0;
        st_d = StRot;
      end
      StRot: begin
        if (step_q == SW'(CordicSteps)) begin
          st_d = StFin;
        end else begin
          if (!z_q[33]) begin
            x_d = x_q - ys; y_d = y_q + xs;
            z_d = z_q - 34'(crpg_pkg::atan_turn(5'(step_q)));
          end else begin
            x_d = x_q + ys; y_d = y_q - xs;
            z_d = z_q + 34'(crpg_pkg::atan_turn(5'(step_q)));
          end
          step_d = step_q + 1'b1;
        end
      end
      StFin: begin
        if (job_q.centre) begin
          px_d = '0; py_d = '0;
        end else begin
          px_d = fin(rx); py_d = fin(ry);
        end
        ov_d = 1'b1;
        st_d = StOut;
      end
      StOut: begin
        if (out_ready_i) begin
          ov_d = 1'b0;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && job_valid_i) job_q <= job_i;
    cnt_q <= cnt_d; num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d;
    rad_q <= rad_d; turn_q <= turn_d; x_q <= x_d; y_q <= y_d; z_q <= z_d;
    step_q <= step_d; quad_q <= quad_d; px_q <= px_d; py_q <= py_d;
  end

  assign out_valid_o   = ov_q;
  assign pos_x_o       = px_q;
  assign pos_y_o       = py_q;
  assign ring_index_o  = job_q.ring;
  assign point_index_o = job_q.point;
  assign last_o        = job_q.last;
endmodule

FILE: rtl/concentric_ring_point_generator.sv
// Top level of the concentric-ring point generator: config registers,
// sequencer, job queue and point engine. Depends on crpg_pkg, crpg_if.
//
//  channel  dir  payload                                       word when
//  req      in   restart                                       valid && ready
//  pt       out  pos_x pos_y ring_index point_index last       valid && ready
//  cfg      in   index data                                    valid && ready
//
// A ring point passes through the two bit-serial divisions and the shared
// CORDIC; the centre point skips them. Reset clears the state, counters and
// config registers, not the datapath, with no clearing pass.
// The sequencer runs ahead by up to three words while the engine or the
// sink stalls.
module concentric_ring_point_generator #(
  parameter int unsigned MaxRings    = crpg_pkg::MaxRingsDef,
  parameter int unsigned MaxSpokes   = crpg_pkg::MaxSpokesDef,
  parameter int unsigned PosWidth    = crpg_pkg::PosWidthDef,
  parameter int unsigned CordicSteps = crpg_pkg::CordicStepsDef
) (
  input logic clk_i,
  input logic rst_ni,
  crpg_req_if.sink   req,
  crpg_pt_if.source  pt,
  crpg_cfg_if.sink   cfg
);
  logic [crpg_pkg::RadW-1:0] radius_max_q;
  logic [crpg_pkg::CntW-1:0] ring_count_q, spokes_q;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_max_q <= '0;
      ring_count_q <= '0;
      spokes_q     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        crpg_pkg::RegRadiusMax: radius_max_q <= cfg.data;
        crpg_pkg::RegRingCount: ring_count_q <= cfg.data[crpg_pkg::CntW-1:0];
        crpg_pkg::RegSpokes:    spokes_q     <= cfg.data[crpg_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  logic seq_v, seq_r, eng_v, eng_r;
  crpg_pkg::job_t seq_job, eng_job;

  crpg_seq #(.MaxRings(MaxRings), .MaxSpokes(MaxSpokes)) u_seq (
    .clk_i, .rst_ni,
    .req_valid_i(req.valid), .restart_i(req.restart), .req_ready_o(req.ready),
    .ring_count_i(ring_count_q), .spokes_i(spokes_q),
    .job_valid_o(seq_v), .job_o(seq_job), .job_ready_i(seq_r)
  );

  crpg_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(seq_v), .in_job_i(seq_job), .in_ready_o(seq_r),
    .out_valid_o(eng_v), .out_job_o(eng_job), .out_ready_i(eng_r)
  );

  crpg_engine #(.PosWidth(PosWidth), .CordicSteps(CordicSteps)) u_eng (
    .clk_i, .rst_ni,
    .job_valid_i(eng_v), .job_i(eng_job), .job_ready_o(eng_r),
    .radius_max_i(radius_max_q),
    .out_valid_o(pt.valid), .out_ready_i(pt.ready),
    .pos_x_o(pt.pos_x), .pos_y_o(pt.pos_y), .ring_index_o(pt.ring_index),
    .point_index_o(pt.point_index), .last_o(pt.last)
  );

  a_centre_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt.valid && pt.ring_index == '0 |-> pt.pos_x == '0 && pt.pos_y == '0 && !pt.last)
    else $error("centre point not at origin");
  a_last_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt.valid && pt.last |-> pt.ring_index != '0)
    else $error("last flag on centre");
endmodule

FILE: sim/tb_concentric_ring_point_generator.sv
// Testbench for the concentric-ring point generator: predicts every point word
// with its own fixed-point CORDIC and checks the output channel field by field.
// Depends on crpg_pkg, crpg_if and the RTL top level.
module tb_concentric_ring_point_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PosW = crpg_pkg::PosWidthDef;
  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic signed [PosW-1:0]           pos_x;
    logic signed [PosW-1:0]           pos_y;
    logic [crpg_pkg::CntW-1:0]        ring_index;
    logic [crpg_pkg::PntW-1:0]        point_index;
    logic                             last;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  crpg_req_if req ();
  crpg_pt_if #(.PosWidth(PosW)) pt ();
  crpg_cfg_if cfg ();

  concentric_ring_point_generator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req.sink),
    .pt    (pt.source),
    .cfg   (cfg.sink)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state
  logic [crpg_pkg::RadW-1:0] pat_radius;
  logic [crpg_pkg::CntW-1:0] pat_rings;
  logic [crpg_pkg::CntW-1:0] pat_spokes;
  logic [crpg_pkg::CntW-1:0] next_ring;
  logic [crpg_pkg::PntW-1:0] next_point;

  point_t pending_points[$];
  int unsigned errors = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  function automatic logic signed [PosW-1:0] round_sat(input longint v);
    longint hi;
    longint lo;
    longint t;
    hi = (longint'(1) <<< (PosW - 1)) - 1;
    lo = -hi - 1;
    t = (v + (longint'(1) <<< (crpg_pkg::GuardBits - 1))) >>> crpg_pkg::GuardBits;
    if (t > hi) t = hi;
    if (t < lo) t = lo;
    return t[PosW-1:0];
  endfunction

  // Own copy of the arctangent table, in 2^-32 turn
  function automatic logic [31:0] atan_table(input int i);
    logic [31:0] tbl[32];
    tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
            32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
            32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
    return tbl[i];
  endfunction

  function automatic void polar_to_xy(input longint unsigned r, input logic [31:0] turn,
                                      output logic signed [PosW-1:0] px,
                                      output logic signed [PosW-1:0] py);
    logic [31:0] quad_sum;
    logic [1:0] quad;
    logic [31:0] resid;
    longint z;
    longint x;
    longint y;
    longint xs;
    longint ys;
    longint rx;
    longint ry;
    longint unsigned prod;
    quad_sum = turn + 32'h2000_0000;
    quad = quad_sum[31:30];
    resid = turn - {quad, 30'd0};
    z = longint'($signed(resid));
    prod = r * longint'(crpg_pkg::GainQ30);
    x = longint'(prod >> (30 - crpg_pkg::GuardBits));
    y = 0;
    for (int i = 0; i < crpg_pkg::CordicStepsDef && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_table(i));
      end else begin
        x += ys; y -= xs; z += longint'(atan_table(i));
      end
    end
    case (quad)
      2'd0: begin rx = x;  ry = y;  end
      2'd1: begin rx = -y; ry = x;  end
      2'd2: begin rx = -x; ry = -y; end
      default: begin rx = y; ry = -x; end
    endcase
    px = round_sat(rx);
    py = round_sat(ry);
  endfunction

  // Advance the pattern by one request and queue the point it yields, if any
  function automatic void predict_point(input logic restart);
    int unsigned nr;
    int unsigned ns;
    int unsigned k;
    int unsigned j;
    int unsigned n;
    longint unsigned r;
    longint unsigned turn;
    point_t p;
    nr = (pat_rings < crpg_pkg::MaxRingsDef) ? pat_rings : crpg_pkg::MaxRingsDef;
    ns = (pat_spokes < crpg_pkg::MaxSpokesDef) ? pat_spokes : crpg_pkg::MaxSpokesDef;
    if (restart) begin
      next_ring = '0; next_point = '0;
    end
    if (nr == 0 || ns == 0) begin
      next_ring = '0; next_point = '0;
      return;
    end
    k = next_ring;
    j = next_point;
    n = 0;
    if (k > nr || (k > 0 && j >= ns * k)) begin
      k = 0; j = 0;
    end
    p = '0;
    if (k != 0) begin
      r = (longint'(pat_radius) * k) / nr;
      n = ns * k;
      turn = (longint'(j) << 32) / n;
      polar_to_xy(r, turn[31:0], p.pos_x, p.pos_y);
      p.last = (k == nr) && (j == n - 1);
    end
    p.ring_index = k[crpg_pkg::CntW-1:0];
    p.point_index = j[crpg_pkg::PntW-1:0];
    pending_points.push_back(p);
    if (k == 0) begin
      k = 1; j = 0;
    end else if (j + 1 >= n) begin
      k = (k == nr) ? 0 : k + 1; j = 0;
    end else begin
      j++;
    end
    next_ring = k[crpg_pkg::CntW-1:0];
    next_point = j[crpg_pkg::PntW-1:0];
  endfunction

  initial begin
    req.valid = 1'b0;
    req.restart = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = crpg_pkg::RegRadiusMax;
    cfg.data = '0;
    pt.ready = 1'b0;
    pat_radius = '0; pat_rings = '0; pat_spokes = '0;
    next_ring = '0; next_point = '0;
  end

  // Sink side: random stall, then check each accepted word
  always @(posedge clk_i) begin
    point_t got;
    point_t want;
    if (rst_ni) begin
      if (pt.valid && pt.ready) begin
        got = '{pt.pos_x, pt.pos_y, pt.ring_index, pt.point_index, pt.last};
        words_out++;
        if (pending_points.size() == 0) begin
          errors++;
          $display("%0t: unexpected point word %p", $time, got);
        end else begin
          want = pending_points.pop_front();
          if (got.pos_x !== want.pos_x)
            $display("%0t: pos_x expected %0d got %0d", $time, want.pos_x, got.pos_x);
          if (got.pos_y !== want.pos_y)
            $display("%0t: pos_y expected %0d got %0d", $time, want.pos_y, got.pos_y);
          if (got.ring_index !== want.ring_index)
            $display("%0t: ring_index expected %0d got %0d", $time,
                     want.ring_index, got.ring_index);
          if (got.point_index !== want.point_index)
            $display("%0t: point_index expected %0d got %0d", $time,
                     want.point_index, got.point_index);
          if (got.last !== want.last)
            $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
          if (got !== want) errors++;
        end
      end
      pt.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog on cycles with no word moving on any channel
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (pt.valid && pt.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d points outstanding", $time,
               pending_points.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Leave valid high after the word so that requests can follow back to back
  task automatic send_request(input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.restart <= restart;
    do @(posedge clk_i); while (!req.ready);
    predict_point(restart);
    words_in++;
  endtask

  task automatic write_reg(input logic [crpg_pkg::CfgIdxW-1:0] idx,
                           input logic [crpg_pkg::CfgDatW-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      crpg_pkg::RegRadiusMax: pat_radius = val[crpg_pkg::RadW-1:0];
      crpg_pkg::RegRingCount: pat_rings = val[crpg_pkg::CntW-1:0];
      crpg_pkg::RegSpokes:    pat_spokes = val[crpg_pkg::CntW-1:0];
      default: ;
    endcase
  endtask

  // Drop the request, wait for the queue to empty, then for anything in flight
  task automatic drain();
    req.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_pattern(input logic [30:0] radius, input logic [7:0] rings,
                             input logic [7:0] nspk);
    drain();
    write_reg(crpg_pkg::RegRadiusMax, radius);
    write_reg(crpg_pkg::RegRingCount, {23'd0, rings});
    write_reg(crpg_pkg::RegSpokes, {23'd0, nspk});
    cfg.valid <= 1'b0;
  endtask

  task automatic test_disabled();
    send_request(1'b0);
    send_request(1'b1);
    set_pattern(31'h7FFF_FFFF, 8'd0, 8'd3);
    send_request(1'b0);
    set_pattern(31'h7FFF_FFFF, 8'd2, 8'd0);
    send_request(1'b1);
  endtask

  task automatic test_directed();
    // Full-scale radius saturates at the axes; one small pattern end to end
    set_pattern(31'h7FFF_FFFF, 8'd1, 8'd4);
    repeat (6) send_request(1'b0);
    set_pattern(31'h0001_0000, 8'd2, 8'd3);
    repeat (11) send_request(1'b0);
    send_request(1'b1);
    // Shrink the pattern mid-way: stored point falls outside, centre follows
    repeat (4) send_request(1'b0);
    set_pattern(31'h0000_0001, 8'd1, 8'd1);
    repeat (3) send_request(1'b0);
  endtask

  task automatic test_extremes();
    // Largest counts: only the start of the first ring of a huge pattern is walked
    set_pattern(31'h7FFF_FFFF, 8'd255, 8'd255);
    repeat (30) send_request(1'b0);
    send_request(1'b1);
  endtask

  task automatic test_random(input int unsigned items, input int unsigned idle_pct,
                             input int unsigned stall_pct);
    send_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    for (int unsigned b = 0; b < items / 30; b++) begin
      if ($urandom_range(3) == 0)
        set_pattern(31'($urandom), 8'($urandom_range(255)), 8'($urandom_range(255)));
      else
        set_pattern(31'($urandom), 8'($urandom_range(4)), 8'($urandom_range(1, 6)));
      for (int i = 0; i < 30; i++) send_request($urandom_range(24) == 0);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_disabled();
    test_directed();
    test_extremes();
    test_random(330, 0, 0);
    test_random(330, 79, 0);
    test_random(330, 0, 79);
    test_random(330, 26, 26);
    send_idle_pct = 0;
    sink_stall_pct = 0;
    drain();
    $display("Sent %0d requests, checked %0d points over full, disabled and resized",
             words_in, words_out);
    $display("patterns under four idle and stall mixes; %0d mismatches", errors);
    if (errors == 0 && pending_points.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
